>>> rtl/sensor_record_gap_filler_macros.svh
// ---------------------------------------------------------------------------
// Sensor record gap filler: assertion macros
// Clocked, reset-qualified concurrent assertion wrappers.
// ---------------------------------------------------------------------------
`ifndef SENSOR_RECORD_GAP_FILLER_MACROS_SVH
`define SENSOR_RECORD_GAP_FILLER_MACROS_SVH

// generic form: explicit clock and active-low reset
`define SRGF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// house form: block clock and reset names
`define SRGF_ASSERT_CLK(label, prop, msg) \
	`SRGF_ASSERT(label, clk, arst_n, prop, msg)

`endif

>>> rtl/srgf_pkg.sv
// ---------------------------------------------------------------------------
// srgf_pkg
// Shared constants and types of the sensor record gap filler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srgf_pkg;

	localparam int MAX_FILL       = 32;
	localparam int FILL_W         = $clog2(MAX_FILL + 1);
	localparam int TICKS_PER_FILL = 160;

	// gap / 160 == (gap >> 5) / 5, and x / 5 == (x * 205) >> 10 for x below 1024
	localparam int FILL_PRE_SHIFT   = 5;
	localparam int FILL_RECIP       = 205;
	localparam int FILL_RECIP_W     = 8;
	localparam int FILL_RECIP_SHIFT = 10;
	localparam int FILL_SPAN        = MAX_FILL * TICKS_PER_FILL;
	localparam int FILL_X_W         = $clog2((FILL_SPAN >> FILL_PRE_SHIFT) + 1);
	localparam int FILL_PROD_W      = FILL_X_W + FILL_RECIP_W;

	localparam int GAP_THR_W      = 31;
	localparam int GAP_THR_RESET  = 240;

	localparam logic [7:0] ACCEPT_KIND   = 8'h37;
	localparam logic [7:0] ACCEPT_LENGTH = 8'd100;
	localparam logic [1:0] COUNT_SAT     = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [31:0] sample_ticks;
		logic [15:0] accel_x;
		logic [15:0] accel_y;
		logic [15:0] accel_z;
		logic [15:0] gyro_x;
		logic [15:0] gyro_y;
		logic [15:0] gyro_z;
		logic [15:0] supply_voltage;
		logic [15:0] temperature;
	} record_t;

	// one queued job: the record itself, then its filler count
	typedef struct packed {
		record_t            rec;
		logic [FILL_W-1:0]  fill;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/srgf_if.sv
// ---------------------------------------------------------------------------
// srgf_if
// Valid/ready channels for sensor records in and result items out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srgf_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  message_kind;
	logic [7:0]  payload_length;
	logic [31:0] sample_ticks;
	logic [15:0] accel_x;
	logic [15:0] accel_y;
	logic [15:0] accel_z;
	logic [15:0] gyro_x;
	logic [15:0] gyro_y;
	logic [15:0] gyro_z;
	logic [15:0] supply_voltage;
	logic [15:0] temperature;

	modport source (
		output valid, message_kind, payload_length, sample_ticks,
		output accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		output supply_voltage, temperature,
		input  ready
	);
	modport sink (
		input  valid, message_kind, payload_length, sample_ticks,
		input  accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		input  supply_voltage, temperature,
		output ready
	);
endinterface

interface srgf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_time;
	logic [15:0] out_accel_x;
	logic [15:0] out_accel_y;
	logic [15:0] out_accel_z;
	logic [15:0] out_gyro_x;
	logic [15:0] out_gyro_y;
	logic [15:0] out_gyro_z;
	logic [15:0] out_voltage;
	logic [15:0] out_temperature;
	logic        is_filler;
	logic        last_of_run;

	modport source (
		output valid, out_time, out_accel_x, out_accel_y, out_accel_z,
		output out_gyro_x, out_gyro_y, out_gyro_z, out_voltage, out_temperature,
		output is_filler, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, out_time, out_accel_x, out_accel_y, out_accel_z,
		input  out_gyro_x, out_gyro_y, out_gyro_z, out_voltage, out_temperature,
		input  is_filler, last_of_run,
		output ready
	);
	modport monitor (
		input  valid, out_time, out_accel_x, out_accel_y, out_accel_z,
		input  out_gyro_x, out_gyro_y, out_gyro_z, out_voltage, out_temperature,
		input  is_filler, last_of_run, ready
	);
endinterface

`default_nettype wire

>>> rtl/srgf_queue.sv
// ---------------------------------------------------------------------------
// srgf_queue
// Small flop-based FIFO of jobs between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srgf_queue import srgf_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic push_valid,
	input  wire  cmd_t push_data,
	output logic       push_ready,
	output logic       pop_valid,
	output cmd_t       pop_data,
	input  wire  logic pop_ready
);

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/srgf_front.sv
// ---------------------------------------------------------------------------
// srgf_front
// Filters records, tracks history and works out the filler count per record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srgf_front import srgf_pkg::*; (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  logic                 gap_threshold_we,
	input  wire  logic [GAP_THR_W-1:0] gap_threshold_wdata,
	srgf_in_if.sink                    sample,
	output logic                       push_valid,
	output cmd_t                       push_data,
	input  wire  logic                 push_ready
);

	logic [GAP_THR_W-1:0]   gap_threshold_q;
	logic [31:0]            prev_time_q;
	logic [1:0]             emitted_q;

	logic                   valid_s1;
	record_t                rec_s1;
	logic                   gap_ok_s1;
	logic [30:0]            gap_s1;

	logic                   accept;
	logic                   keep;
	logic [31:0]            diff;
	logic                   gap_ok;
	record_t                rec_in;
	logic                   over_span;
	logic [FILL_X_W-1:0]    fill_x;
	logic [FILL_PROD_W-1:0] fill_prod;
	logic [FILL_W-1:0]      fill;

	assign sample.ready = !valid_s1 || push_ready;
	assign accept       = sample.valid && sample.ready;
	assign keep         = (sample.message_kind == ACCEPT_KIND)
	                   && (sample.payload_length == ACCEPT_LENGTH);

	assign rec_in = '{
		sample_ticks:   sample.sample_ticks,
		accel_x:        sample.accel_x,
		accel_y:        sample.accel_y,
		accel_z:        sample.accel_z,
		gyro_x:         sample.gyro_x,
		gyro_y:         sample.gyro_y,
		gyro_z:         sample.gyro_z,
		supply_voltage: sample.supply_voltage,
		temperature:    sample.temperature
	};

	// gap is a wrapped difference read as signed; a negative one never fills
	assign diff   = sample.sample_ticks - prev_time_q;
	assign gap_ok = (emitted_q == COUNT_SAT) && (prev_time_q != '0)
	             && ($signed(diff) > $signed({1'b0, gap_threshold_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_threshold_q <= GAP_THR_W'(GAP_THR_RESET);
			prev_time_q     <= '0;
			emitted_q       <= '0;
			valid_s1        <= 1'b0;
		end else begin
			if (gap_threshold_we) begin
				gap_threshold_q <= gap_threshold_wdata;
			end
			if (accept && keep) begin
				prev_time_q <= sample.sample_ticks;
				// any filler only comes once the count is already saturated
				if (emitted_q != COUNT_SAT) begin
					emitted_q <= emitted_q + 1'b1;
				end
			end
			if (sample.ready) begin
				valid_s1 <= accept && keep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			rec_s1    <= rec_in;
			gap_ok_s1 <= gap_ok;
			gap_s1    <= diff[30:0];
		end
	end

	// gap / 160 through a shift and a reciprocal multiply, capped at the fill limit
	assign over_span = (gap_s1 >= 31'(FILL_SPAN));
	assign fill_x    = FILL_X_W'(gap_s1 >> FILL_PRE_SHIFT);
	assign fill_prod = FILL_PROD_W'(fill_x) * FILL_PROD_W'(FILL_RECIP);

	always_comb begin
		if (!gap_ok_s1) begin
			fill = '0;
		end else if (over_span) begin
			fill = FILL_W'(MAX_FILL);
		end else begin
			fill = FILL_W'(fill_prod >> FILL_RECIP_SHIFT);
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = '{rec: rec_s1, fill: fill};

endmodule

`default_nettype wire

>>> rtl/srgf_back.sv
// ---------------------------------------------------------------------------
// srgf_back
// Plays out each job: the filler records, then the record with its last flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srgf_back import srgf_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic pop_valid,
	input  wire  cmd_t pop_data,
	output logic       pop_ready,
	srgf_out_if.source result
);

	logic              active_q;
	logic [FILL_W-1:0] fill_left_q;
	record_t           rec_q;

	logic              out_valid_q;
	record_t           out_rec_q;
	logic              out_filler_q;
	logic              out_last_q;

	logic              produce;
	logic              finishing;
	logic              pop;

	assign produce   = active_q && (!out_valid_q || result.ready);
	assign finishing = produce && (fill_left_q == '0);
	assign pop_ready = !active_q || finishing;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			fill_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q    <= 1'b1;
				fill_left_q <= pop_data.fill;
			end else if (finishing) begin
				active_q <= 1'b0;
			end else if (produce) begin
				fill_left_q <= fill_left_q - 1'b1;
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= pop_data.rec;
		end
		if (produce) begin
			out_rec_q    <= finishing ? rec_q : '0;
			out_filler_q <= !finishing;
			out_last_q   <= finishing;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.out_time        = out_rec_q.sample_ticks;
	assign result.out_accel_x     = out_rec_q.accel_x;
	assign result.out_accel_y     = out_rec_q.accel_y;
	assign result.out_accel_z     = out_rec_q.accel_z;
	assign result.out_gyro_x      = out_rec_q.gyro_x;
	assign result.out_gyro_y      = out_rec_q.gyro_y;
	assign result.out_gyro_z      = out_rec_q.gyro_z;
	assign result.out_voltage     = out_rec_q.supply_voltage;
	assign result.out_temperature = out_rec_q.temperature;
	assign result.is_filler       = out_filler_q;
	assign result.last_of_run     = out_last_q;

endmodule

`default_nettype wire

>>> rtl/sensor_record_gap_filler.sv
// A kept record passes the front stage register, the job queue, and the back
// end's job and output registers; it shows after any filler items ahead of it.
// Throughput: one result item per cycle while the receiver is ready; a record
// with F filler items gives F + 1 items via the single output register.
// Dropped records take an input transfer and give nothing.
// Reset (arst_n low): history cleared, gap threshold back to 240, queue emptied.
`timescale 1ns / 1ps
`default_nettype none

// ---------------------------------------------------------------------------
// sensor_record_gap_filler
// Drops foreign records and inserts zero filler records across timestamp gaps.
// ---------------------------------------------------------------------------
module sensor_record_gap_filler import srgf_pkg::*; (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  logic                 gap_threshold_we,
	input  wire  logic [GAP_THR_W-1:0] gap_threshold_wdata,
	srgf_in_if.sink                    sample,
	srgf_out_if.source                 result
);

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	srgf_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.gap_threshold_we    (gap_threshold_we),
		.gap_threshold_wdata (gap_threshold_wdata),
		.sample              (sample),
		.push_valid          (push_valid),
		.push_data           (push_data),
		.push_ready          (push_ready)
	);

	srgf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	srgf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

`default_nettype wire

>>> rtl/srgf_checker.sv
// ---------------------------------------------------------------------------
// srgf_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sensor_record_gap_filler_macros.svh"

module srgf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [31:0] out_time,
	input wire logic [15:0] out_accel_x,
	input wire logic [15:0] out_temperature,
	input wire logic        is_filler,
	input wire logic        last_of_run
);

	`SRGF_ASSERT_CLK(a_stall_holds, valid && !ready |=> valid && $stable(out_time) && $stable(is_filler), "result changed while stalled")

	`SRGF_ASSERT_CLK(a_filler_zero, valid && is_filler |-> out_time == 32'd0 && out_accel_x == 16'd0 && out_temperature == 16'd0, "filler item not zero")

	`SRGF_ASSERT_CLK(a_kind_flags, valid |-> is_filler != last_of_run, "filler and last flags clash")

	`SRGF_ASSERT_CLK(a_run_continues, valid && ready && is_filler |=> valid, "run broken after filler transfer")

endmodule

bind sensor_record_gap_filler srgf_checker u_srgf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.valid           (result.valid),
	.ready           (result.ready),
	.out_time        (result.out_time),
	.out_accel_x     (result.out_accel_x),
	.out_temperature (result.out_temperature),
	.is_filler       (result.is_filler),
	.last_of_run     (result.last_of_run)
);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sensor record gap filler testbench
// Drives records (kept, foreign and malformed) through the input channel and
// checks every result item against a cycle-free predictor of the filler logic.
// Covers each gap threshold extreme, long output stalls and random idling.
// ---------------------------------------------------------------------------
module testbench import srgf_pkg::*; ();

	localparam int RESET_CYCLES     = 12;
	localparam int BURST_MAX        = 19;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES     = 10;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam logic [GAP_THR_W-1:0] THR_MAX = {GAP_THR_W{1'b1}};

	typedef struct packed {
		logic [7:0] kind;
		logic [7:0] len;
		record_t    rec;
	} sample_item_t;

	typedef struct packed {
		record_t rec;
		logic    is_filler;
		logic    last_of_run;
	} run_item_t;

	logic clk;
	logic arst_n;
	logic gap_threshold_we;
	logic [GAP_THR_W-1:0] gap_threshold_wdata;

	srgf_in_if  sample_if ();
	srgf_out_if result_if ();

	sensor_record_gap_filler dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.gap_threshold_we    (gap_threshold_we),
		.gap_threshold_wdata (gap_threshold_wdata),
		.sample              (sample_if),
		.result              (result_if)
	);

	// predictor state, mirrors the block after reset
	logic [1:0]           model_count     = '0;
	logic [31:0]          model_prev_time = '0;
	logic [GAP_THR_W-1:0] model_threshold = GAP_THR_W'(GAP_THR_RESET);

	sample_item_t sample_backlog[$];
	run_item_t    predicted_items[$];
	sample_item_t current_sample;
	run_item_t    head_item;
	logic [31:0]  gen_time;

	int fail_count   = 0;
	int src_idle_pct = 0;
	int rx_idle_pct  = 0;
	int src_idle     = 0;
	int rx_idle      = 0;
	int rx_hold      = 0;
	int holds_asked  = 0;
	int holds_served = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	function automatic void predict_fill_run(input sample_item_t s);
		logic [31:0] gap;
		int unsigned fill;
		int unsigned total;
		run_item_t   item;
		if (s.kind != ACCEPT_KIND || s.len != ACCEPT_LENGTH)
			return;
		fill = 0;
		if (model_count == COUNT_SAT && model_prev_time != 32'd0) begin
			gap = s.rec.sample_ticks - model_prev_time;
			// signed compare: a negative gap never fills
			if (!gap[31] && gap[30:0] > model_threshold) begin
				fill = gap / TICKS_PER_FILL;
				if (fill > MAX_FILL)
					fill = MAX_FILL;
			end
		end
		item = '0;
		item.is_filler = 1'b1;
		repeat (fill) predicted_items.push_back(item);
		item.rec = s.rec;
		item.is_filler = 1'b0;
		item.last_of_run = 1'b1;
		predicted_items.push_back(item);
		total = model_count + fill + 1;
		model_count = (total > COUNT_SAT) ? COUNT_SAT : total[1:0];
		model_prev_time = s.rec.sample_ticks;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic sample_item_t random_sample(input logic [GAP_THR_W-1:0] thr);
		sample_item_t s;
		int unsigned  pick;
		logic [31:0]  step;
		pick = $urandom_range(0, 99);
		s.rec = {$urandom, $urandom, $urandom, $urandom, $urandom};
		s.kind = ACCEPT_KIND;
		s.len = ACCEPT_LENGTH;
		if (pick < 12) begin
			// foreign or malformed message, timestamp left random
			case ($urandom_range(0, 2))
				0: s.len = 8'($urandom);
				1: s.kind = 8'($urandom);
				default: begin
					s.kind = 8'($urandom);
					s.len = 8'($urandom);
				end
			endcase
			return s;
		end
		step = '0;
		if (pick < 45)
			step = $urandom_range(0, 400);
		else if (pick < 60)
			step = {1'b0, thr} + $urandom_range(0, 2) - 32'd1;
		else if (pick < 80)
			step = {1'b0, thr} + $urandom_range(1, 6000);
		else if (pick < 88)
			step = 32'd0 - $urandom_range(1, 100000);
		else if (pick < 94)
			gen_time = $urandom;
		else
			gen_time = '0;
		gen_time = gen_time + step;
		s.rec.sample_ticks = gen_time;
		return s;
	endfunction

	task automatic push_directed(input logic [7:0] kind, input logic [7:0] len,
			input logic [31:0] ts, input logic fixed_on, input logic [15:0] fixed);
		sample_item_t s;
		s.kind = kind;
		s.len = len;
		s.rec = {$urandom, $urandom, $urandom, $urandom, $urandom};
		s.rec.sample_ticks = ts;
		if (fixed_on)
			s.rec[127:0] = {8{fixed}};
		sample_backlog.push_back(s);
		gen_time = ts;
	endtask

	task automatic wait_idle();
		while (sample_backlog.size() != 0 || sample_if.valid || predicted_items.size() != 0)
			@(posedge clk);
		// dropped records may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [GAP_THR_W-1:0] value);
		@(posedge clk);
		gap_threshold_we <= 1'b1;
		gap_threshold_wdata <= value;
		@(posedge clk);
		gap_threshold_we <= 1'b0;
		model_threshold = value;
	endtask

	task automatic run_phase(input logic [GAP_THR_W-1:0] thr, input int count,
			input int src_pct, input int rx_pct, input logic long_hold);
		wait_idle();
		write_threshold(thr);
		@(negedge clk);
		src_idle_pct = src_pct;
		rx_idle_pct = rx_pct;
		if (long_hold)
			holds_asked++;
		repeat (count) sample_backlog.push_back(random_sample(thr));
	endtask

	// sender: one transfer per handshake, random idle bursts between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
			src_idle <= 0;
		end else begin
			if (sample_if.valid && sample_if.ready)
				predict_fill_run(current_sample);
			if (!sample_if.valid || sample_if.ready) begin
				if (src_idle != 0) begin
					src_idle <= src_idle - 1;
					sample_if.valid <= 1'b0;
				end else if (sample_backlog.size() != 0 &&
						$urandom_range(0, 99) < src_idle_pct) begin
					src_idle <= $urandom_range(1, BURST_MAX) - 1;
					sample_if.valid <= 1'b0;
				end else if (sample_backlog.size() != 0) begin
					current_sample = sample_backlog.pop_front();
					sample_if.message_kind <= current_sample.kind;
					sample_if.payload_length <= current_sample.len;
					sample_if.sample_ticks <= current_sample.rec.sample_ticks;
					sample_if.accel_x <= current_sample.rec.accel_x;
					sample_if.accel_y <= current_sample.rec.accel_y;
					sample_if.accel_z <= current_sample.rec.accel_z;
					sample_if.gyro_x <= current_sample.rec.gyro_x;
					sample_if.gyro_y <= current_sample.rec.gyro_y;
					sample_if.gyro_z <= current_sample.rec.gyro_z;
					sample_if.supply_voltage <= current_sample.rec.supply_voltage;
					sample_if.temperature <= current_sample.rec.temperature;
					sample_if.valid <= 1'b1;
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts, plus a long hold when asked for
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			rx_idle <= 0;
			rx_hold <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			rx_hold <= LONG_HOLD_CYCLES;
			result_if.ready <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			result_if.ready <= 1'b0;
		end else if (rx_idle != 0) begin
			rx_idle <= rx_idle - 1;
			result_if.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < rx_idle_pct) begin
			rx_idle <= $urandom_range(1, BURST_MAX) - 1;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (predicted_items.size() == 0) begin
				$error("result transfer with nothing expected, out_time %h",
					result_if.out_time);
				fail_count++;
			end else begin
				head_item = predicted_items.pop_front();
				check_field("out_time", head_item.rec.sample_ticks, result_if.out_time);
				check_field("out_accel_x", head_item.rec.accel_x, result_if.out_accel_x);
				check_field("out_accel_y", head_item.rec.accel_y, result_if.out_accel_y);
				check_field("out_accel_z", head_item.rec.accel_z, result_if.out_accel_z);
				check_field("out_gyro_x", head_item.rec.gyro_x, result_if.out_gyro_x);
				check_field("out_gyro_y", head_item.rec.gyro_y, result_if.out_gyro_y);
				check_field("out_gyro_z", head_item.rec.gyro_z, result_if.out_gyro_z);
				check_field("out_voltage", head_item.rec.supply_voltage,
					result_if.out_voltage);
				check_field("out_temperature", head_item.rec.temperature,
					result_if.out_temperature);
				check_field("is_filler", head_item.is_filler, result_if.is_filler);
				check_field("last_of_run", head_item.last_of_run, result_if.last_of_run);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (sample_if.valid && sample_if.ready) ||
				(result_if.valid && result_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		gap_threshold_we = 1'b0;
		gap_threshold_wdata = '0;
		sample_if.valid = 1'b0;
		sample_if.message_kind = '0;
		sample_if.payload_length = '0;
		sample_if.sample_ticks = '0;
		sample_if.accel_x = '0;
		sample_if.accel_y = '0;
		sample_if.accel_z = '0;
		sample_if.gyro_x = '0;
		sample_if.gyro_y = '0;
		sample_if.gyro_z = '0;
		sample_if.supply_voltage = '0;
		sample_if.temperature = '0;
		result_if.ready = 1'b0;
		gen_time = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset threshold
		src_idle_pct = 10;
		rx_idle_pct = 10;
		push_directed(ACCEPT_KIND, 8'd99, $urandom, 1'b0, '0);
		push_directed(8'h36, ACCEPT_LENGTH, $urandom, 1'b0, '0);
		push_directed(8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd0, 1'b1, 16'h0000);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		// count not yet saturated: wrapped gap ignored
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd100, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd340, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd581, 1'b0, '0);
		// dropped record must leave the history alone
		push_directed(8'h00, ACCEPT_LENGTH, 32'd0, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd6581, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd100, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd5220, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd10339, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd10819, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd0, 1'b0, '0);
		// zero previous time: no filler whatever the gap
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'd50000, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'h8000_C350, 1'b0, '0);
		push_directed(ACCEPT_KIND, ACCEPT_LENGTH, 32'h0000_C34F, 1'b0, '0);
		push_directed(ACCEPT_KIND, 8'd0, 32'd12345, 1'b0, '0);

		run_phase('0, 50, 15, 15, 1'b0);
		run_phase(THR_MAX, 40, 15, 15, 1'b0);
		run_phase(GAP_THR_W'(800), 60, 0, 10, 1'b1);
		run_phase(GAP_THR_W'($urandom_range(0, 20000)), 40, 0, 0, 1'b0);
		run_phase(GAP_THR_W'(GAP_THR_RESET), 50, 20, 20, 1'b0);
		run_phase(GAP_THR_W'($urandom), 20, 10, 10, 1'b0);
		run_phase(GAP_THR_W'(1), 40, 0, 0, 1'b0);
		wait_idle();

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/srgf_pkg.sv
rtl/srgf_if.sv
rtl/srgf_queue.sv
rtl/srgf_front.sv
rtl/srgf_back.sv
rtl/sensor_record_gap_filler.sv
rtl/srgf_checker.sv
bench/testbench.sv
